@@ src/clp_pkg.sv @@
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types, token kinds and character tables for the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package clp_pkg;

  localparam int MaxWordLenDefault    = 128;
  localparam int PositionWidthDefault = 16;
  localparam int NumKeywords          = 6;

  localparam logic [30:0] LitMax = 31'h7FFF_FFFF;
  localparam logic [7:0]  ChNul  = 8'h00;

  // token kinds
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_INT     = 5'd1;
  localparam logic [4:0] KIND_IDENT   = 5'd7;
  localparam logic [4:0] KIND_LITERAL = 5'd8;
  localparam logic [4:0] KIND_LBRACE  = 5'd9;
  localparam logic [4:0] KIND_RBRACE  = 5'd10;
  localparam logic [4:0] KIND_LPAREN  = 5'd11;
  localparam logic [4:0] KIND_RPAREN  = 5'd12;
  localparam logic [4:0] KIND_SEMI    = 5'd13;
  localparam logic [4:0] KIND_STAR    = 5'd14;
  localparam logic [4:0] KIND_PLUS    = 5'd15;
  localparam logic [4:0] KIND_MINUS   = 5'd16;
  localparam logic [4:0] KIND_SLASH   = 5'd17;
  localparam logic [4:0] KIND_BANG    = 5'd18;
  localparam logic [4:0] KIND_ASSIGN  = 5'd19;
  localparam logic [4:0] KIND_GT      = 5'd20;
  localparam logic [4:0] KIND_LT      = 5'd21;
  localparam logic [4:0] KIND_EQ      = 5'd22;
  localparam logic [4:0] KIND_NE      = 5'd23;
  localparam logic [4:0] KIND_GE      = 5'd24;
  localparam logic [4:0] KIND_LE      = 5'd25;
  localparam logic [4:0] KIND_INCR    = 5'd26;
  localparam logic [4:0] KIND_DECR    = 5'd27;
  localparam logic [4:0] KIND_ADD_EQ  = 5'd28;
  localparam logic [4:0] KIND_SUB_EQ  = 5'd29;
  localparam logic [4:0] KIND_AND     = 5'd30;
  localparam logic [4:0] KIND_OR      = 5'd31;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_NUL,
    CLS_ALPHA,
    CLS_DIGIT,
    CLS_HOLD,
    CLS_SINGLE
  } class_e;

  typedef struct packed {
    logic [7:0] ch;
    class_e     cls;
  } clp_item_t;

  function automatic logic [4:0] single_kind(input logic [7:0] ch);
    logic [4:0] k;
    case (ch)
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ";":     k = KIND_SEMI;
      "*":     k = KIND_STAR;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "/":     k = KIND_SLASH;
      "!":     k = KIND_BANG;
      "=":     k = KIND_ASSIGN;
      ">":     k = KIND_GT;
      "<":     k = KIND_LT;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic is_holdable(input logic [7:0] ch);
    return ch inside {"=", "!", ">", "<", "+", "-", "&", "|"};
  endfunction

  // KIND_EOF when the two bytes make no pair
  function automatic logic [4:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [4:0] k;
    k = KIND_EOF;
    if (c == "=") begin
      case (h)
        "=":     k = KIND_EQ;
        "!":     k = KIND_NE;
        ">":     k = KIND_GE;
        "<":     k = KIND_LE;
        "+":     k = KIND_ADD_EQ;
        "-":     k = KIND_SUB_EQ;
        default: k = KIND_EOF;
      endcase
    end else if (h == c) begin
      case (h)
        "+":     k = KIND_INCR;
        "-":     k = KIND_DECR;
        "&":     k = KIND_AND;
        "|":     k = KIND_OR;
        default: k = KIND_EOF;
      endcase
    end
    return k;
  endfunction

  // keyword character at a position; NUL past the end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [6:0] idx);
    logic [47:0] txt;
    case (k)
      3'd0:    txt = {"int", 24'h0};
      3'd1:    txt = "return";
      3'd2:    txt = {"if", 32'h0};
      3'd3:    txt = {"else", 16'h0};
      3'd4:    txt = {"while", 8'h0};
      3'd5:    txt = {"for", 24'h0};
      default: txt = '0;
    endcase
    if (idx < 7'd6) begin
      return txt[47 - 8 * int'(idx[2:0]) -: 8];
    end
    return ChNul;
  endfunction

  function automatic logic [6:0] kw_len(input logic [2:0] k);
    logic [6:0] n;
    case (k)
      3'd0:    n = 7'd3;
      3'd1:    n = 7'd6;
      3'd2:    n = 7'd2;
      3'd3:    n = 7'd4;
      3'd4:    n = 7'd5;
      3'd5:    n = 7'd3;
      default: n = 7'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ src/clp_front.sv @@
// ----------------------------------------------------------------------------
// clp_front
// Takes source bytes, classifies each one and stamps its offset in the text.
// ----------------------------------------------------------------------------
`default_nettype none

module clp_front
  import clp_pkg::*;
#(
  parameter int PositionWidth = PositionWidthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [7:0]               ch_i,
  output logic                          item_valid_o,
  input  wire logic                     item_full_i,
  output clp_item_t                     item_o,
  output logic      [PositionWidth-1:0] item_pos_o
);

  logic                     valid_q, valid_d;
  logic                     accept;
  clp_item_t                item_q, item_d;
  logic [PositionWidth-1:0] pos_q, pos_d;
  logic [PositionWidth-1:0] stamp_q;

  assign in_stall_o = valid_q && item_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.ch = ch_i;
    if (ch_i == ChNul) begin
      item_d.cls = CLS_NUL;
    end else if (ch_i inside {["a":"z"], ["A":"Z"], "_"}) begin
      item_d.cls = CLS_ALPHA;
    end else if (ch_i inside {["0":"9"]}) begin
      item_d.cls = CLS_DIGIT;
    end else if (is_holdable(ch_i)) begin
      item_d.cls = CLS_HOLD;
    end else if (single_kind(ch_i) != KIND_EOF) begin
      item_d.cls = CLS_SINGLE;
    end else begin
      item_d.cls = CLS_SKIP;
    end
  end

  // offset restarts at zero after the end of a text
  always_comb begin
    pos_d   = pos_q;
    valid_d = accept || (valid_q && item_full_i);
    if (accept) begin
      pos_d = (ch_i == ChNul) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= item_d;
      stamp_q <= pos_q;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign item_pos_o   = stamp_q;

endmodule

`default_nettype wire

@@ src/clp_queue.sv @@
// ----------------------------------------------------------------------------
// clp_queue
// Small register queue between the classifier and the token engine.
// ----------------------------------------------------------------------------
`default_nettype none

module clp_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [Width-1:0] data_o
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW + 1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/clp_back.sv @@
// ----------------------------------------------------------------------------
// clp_back
// Token engine: keeps the token in progress and queues finished tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module clp_back
  import clp_pkg::*;
#(
  parameter int PositionWidth = PositionWidthDefault,
  parameter int MaxWordLen    = MaxWordLenDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     item_valid_i,
  input  wire clp_item_t                item_i,
  input  wire logic [PositionWidth-1:0] item_pos_i,
  output logic                          item_take_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic      [4:0]               token_kind_o,
  output logic      [30:0]              literal_value_o,
  output logic      [6:0]               token_length_o,
  output logic      [PositionWidth-1:0] start_position_o,
  output logic                          last_of_run_o
);

  localparam int TokDepth = 4;
  localparam int TokPtrW  = $clog2(TokDepth);
  localparam logic [6:0] LenCap = 7'(((MaxWordLen - 1) < 127) ? (MaxWordLen - 1) : 127);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_HELD
  } mode_e;

  typedef struct packed {
    logic [4:0]               kind;
    logic [30:0]              value;
    logic [6:0]               len;
    logic [PositionWidth-1:0] start;
    logic                     last;
  } tok_t;

  function automatic logic [5:0] narrow(input logic [5:0] m, input logic [6:0] idx,
                                        input logic [7:0] c);
    logic [5:0] r;
    r = m;
    for (int k = 0; k < NumKeywords; k++) begin
      if (kw_char(3'(k), idx) != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  // lowest matching keyword wins, else identifier
  function automatic logic [4:0] word_kind(input logic [5:0] m, input logic [6:0] len);
    logic [4:0] kd;
    kd = KIND_IDENT;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if (m[k] && len == kw_len(3'(k))) kd = KIND_INT + 5'(k);
    end
    return kd;
  endfunction

  mode_e                    mode_q, mode_d;
  logic [7:0]               held_q, held_d;
  logic [6:0]               wlen_q, wlen_d;
  logic [5:0]               mask_q, mask_d;
  logic [30:0]              acc_q, acc_d;
  logic [PositionWidth-1:0] tstart_q, tstart_d;

  tok_t                     tok_q [TokDepth];
  logic [TokPtrW-1:0]       wptr_q, rptr_q;
  logic [TokPtrW:0]         tcnt_q;

  logic                     take, pop, room;
  logic                     fresh, fresh_emit;
  logic [1:0]               n_tok;
  tok_t                     t0, t1, ft;
  logic [4:0]               pk;
  logic [6:0]               wlen_bump;
  logic [34:0]              acc10;
  logic [7:0]               c;

  assign pop         = out_valid_o && !out_stall_i;
  assign room        = (int'(tcnt_q) - int'(pop)) <= (TokDepth - 2);
  assign take        = item_valid_i && room;
  assign item_take_o = take;

  assign c         = item_i.ch;
  assign pk        = pair_kind(held_q, c);
  assign wlen_bump = (wlen_q < LenCap) ? wlen_q + 7'd1 : wlen_q;
  assign acc10     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 35'(c[3:0]);

  always_comb begin
    mode_d     = mode_q;
    held_d     = held_q;
    wlen_d     = wlen_q;
    mask_d     = mask_q;
    acc_d      = acc_q;
    tstart_d   = tstart_q;
    t0         = '0;
    t1         = '0;
    ft         = '0;
    n_tok      = 2'd0;
    fresh      = 1'b0;
    fresh_emit = 1'b0;
    if (take) begin
      fresh = 1'b1;
      // first close or extend the token in progress
      case (mode_q)
        MODE_WORD: begin
          if (item_i.cls == CLS_ALPHA || item_i.cls == CLS_DIGIT) begin
            mask_d = narrow(mask_q, wlen_q, c);
            wlen_d = wlen_bump;
            fresh  = 1'b0;
          end else begin
            t0.kind  = word_kind(mask_q, wlen_q);
            t0.len   = wlen_q;
            t0.start = tstart_q;
            n_tok    = 2'd1;
            mode_d   = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (item_i.cls == CLS_DIGIT) begin
            acc_d  = (acc10 > 35'(LitMax)) ? LitMax : acc10[30:0];
            wlen_d = wlen_bump;
            fresh  = 1'b0;
          end else begin
            t0.kind  = KIND_LITERAL;
            t0.value = acc_q;
            t0.len   = wlen_q;
            t0.start = tstart_q;
            n_tok    = 2'd1;
            mode_d   = MODE_IDLE;
          end
        end
        MODE_HELD: begin
          mode_d = MODE_IDLE;
          held_d = '0;
          if (pk != KIND_EOF) begin
            t0.kind  = pk;
            t0.len   = 7'd2;
            t0.start = tstart_q;
            n_tok    = 2'd1;
            fresh    = 1'b0;
          end else if (single_kind(held_q) != KIND_EOF) begin
            // a lone ampersand or bar has no single kind and is dropped
            t0.kind  = single_kind(held_q);
            t0.len   = 7'd1;
            t0.start = tstart_q;
            n_tok    = 2'd1;
          end
        end
        default: ;
      endcase

      // then scan the byte as the start of something new
      if (fresh) begin
        case (item_i.cls)
          CLS_NUL: begin
            fresh_emit = 1'b1;
            ft.kind    = KIND_EOF;
            ft.start   = item_pos_i;
            mode_d     = MODE_IDLE;
            held_d     = '0;
            wlen_d     = '0;
            mask_d     = '1;
            acc_d      = '0;
            tstart_d   = '0;
          end
          CLS_ALPHA: begin
            mode_d   = MODE_WORD;
            tstart_d = item_pos_i;
            mask_d   = narrow('1, 7'd0, c);
            wlen_d   = 7'd1;
          end
          CLS_DIGIT: begin
            mode_d   = MODE_NUM;
            tstart_d = item_pos_i;
            wlen_d   = 7'd1;
            acc_d    = 31'(c[3:0]);
          end
          CLS_HOLD: begin
            mode_d   = MODE_HELD;
            held_d   = c;
            tstart_d = item_pos_i;
          end
          CLS_SINGLE: begin
            fresh_emit = 1'b1;
            ft.kind    = single_kind(c);
            ft.len     = 7'd1;
            ft.start   = item_pos_i;
          end
          default: ;
        endcase
      end

      if (fresh_emit) begin
        if (n_tok == 2'd0) t0 = ft;
        else t1 = ft;
        n_tok = n_tok + 2'd1;
      end
      if (n_tok == 2'd1) t0.last = 1'b1;
      if (n_tok == 2'd2) t1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      held_q   <= '0;
      wlen_q   <= '0;
      mask_q   <= '1;
      acc_q    <= '0;
      tstart_q <= '0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      tcnt_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      wlen_q   <= wlen_d;
      mask_q   <= mask_d;
      acc_q    <= acc_d;
      tstart_q <= tstart_d;
      wptr_q   <= wptr_q + TokPtrW'(n_tok);
      rptr_q   <= rptr_q + TokPtrW'(pop);
      tcnt_q   <= tcnt_q + (TokPtrW + 1)'(n_tok) - (TokPtrW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_tok != 2'd0) tok_q[wptr_q] <= t0;
    if (n_tok == 2'd2) tok_q[wptr_q + 1'b1] <= t1;
  end

  assign out_valid_o      = (tcnt_q != '0);
  assign token_kind_o     = tok_q[rptr_q].kind;
  assign literal_value_o  = tok_q[rptr_q].value;
  assign token_length_o   = tok_q[rptr_q].len;
  assign start_position_o = tok_q[rptr_q].start;
  assign last_of_run_o    = tok_q[rptr_q].last;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcnt_q <= (TokPtrW + 1)'(TokDepth))
    else $error("token queue over capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_tok != 2'd0) |-> take)
    else $error("token pushed without an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_tok == 2'd2) |-> (!t0.last && t1.last))
    else $error("last flag misplaced on a pair of tokens");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.cls == CLS_NUL) |=>
      (mode_q == MODE_IDLE && mask_q == '1 && wlen_q == '0 && acc_q == '0))
    else $error("state not cleared after end of text");
`endif

endmodule

`default_nettype wire

@@ src/c_subset_lexer_core.sv @@
// Throughput: one byte per cycle when nothing stalls; a byte that closes
//   a token and starts a one-character token puts out two tokens, one per
//   output cycle. Path: front register, item queue, then token queue.
// The token engine takes a byte only with two free slots in its 4-deep token
//   queue; the 4-deep item queue absorbs short output stalls.
// Reset (rst_ni low) clears all scanner state at once; no clearing pass.
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// Byte-serial lexer for a small C subset: words with keyword match, decimal
// literals, one- and two-character operators, and an end-of-text token.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer_core
  import clp_pkg::*;
#(
  parameter int MAX_WORD_LEN   = MaxWordLenDefault,
  parameter int POSITION_WIDTH = PositionWidthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // byte input
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [7:0]                ch_i,
  // token output
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [4:0]                token_kind_o,
  output logic      [30:0]               literal_value_o,
  output logic      [6:0]                token_length_o,
  output logic      [POSITION_WIDTH-1:0] start_position_o,
  output logic                           last_of_run_o
);

  // queue entry: classified byte plus its offset in the text
  localparam int ItemW = $bits(clp_item_t) + POSITION_WIDTH;

  logic                      fr_valid;
  logic                      q_full, q_empty, q_pop;
  clp_item_t                 fr_item, bk_item;
  logic [POSITION_WIDTH-1:0] fr_pos, bk_pos;
  logic [ItemW-1:0]          q_out;

  // Front: registers each byte with its class and offset. The offset counter
  // runs independently of the token engine; it restarts after a NUL byte.
  clp_front #(
    .PositionWidth(POSITION_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .item_valid_o(fr_valid),
    .item_full_i (q_full),
    .item_o      (fr_item),
    .item_pos_o  (fr_pos)
  );

  // Decoupling queue: the front keeps taking bytes while the token engine
  // waits on a stalled output.
  clp_queue #(
    .Width(ItemW),
    .Depth(4)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_valid),
    .data_i ({fr_item, fr_pos}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_out)
  );

  assign bk_item = q_out[ItemW-1 -: $bits(clp_item_t)];
  assign bk_pos  = q_out[POSITION_WIDTH-1:0];

  // Back: token in progress, keyword mask narrowing, saturating literal and
  // length, and the token queue that drives the output ports.
  clp_back #(
    .PositionWidth(POSITION_WIDTH),
    .MaxWordLen   (MAX_WORD_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (!q_empty),
    .item_i          (bk_item),
    .item_pos_i      (bk_pos),
    .item_take_o     (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .token_kind_o    (token_kind_o),
    .literal_value_o (literal_value_o),
    .token_length_o  (token_length_o),
    .start_position_o(start_position_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire
